// ===== rtl/sac_pkg.sv =====
// Shared constants, types and command codes for the suffix automaton
// common-substring block. No dependencies; imported by every rtl module but sac_ram.
package sac_pkg;

  localparam int MAX_TEXT   = 1023;
  localparam int MAX_STATES = 2048;
  localparam int ALPHABET   = 26;

  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int SYM_W   = 5;
  localparam int LEN_W   = 10;
  localparam int TEXT_W  = 10;
  localparam int TR_AW   = STATE_W + SYM_W;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [SYM_W-1:0]   sym_t;

  localparam state_t NULL_STATE = state_t'(0);
  localparam state_t ROOT_STATE = state_t'(1);

  // Datapath commands issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT_ROW,
    OP_INIT_LEN,
    OP_ACCEPT,
    OP_T_START,
    OP_T_CLR,
    OP_T_LENW,
    OP_T_TOP,
    OP_T_CHK,
    OP_FOLLOW,
    OP_T_LQ,
    OP_T_LP,
    OP_C_LEN,
    OP_C_LNK,
    OP_C_LNK2,
    OP_C_LNK3,
    OP_C_RD,
    OP_C_WR,
    OP_R_TOP,
    OP_R_CHK,
    OP_T_DONE,
    OP_Q_START,
    OP_Q_BAD,
    OP_Q_CHK0,
    OP_Q_TOP,
    OP_Q_CHK,
    OP_Q_LEN,
    OP_Q_BEST,
    OP_PUT
  } sac_op_e;

  // Status flags returned by the datapath
  typedef struct packed {
    logic kind;
    logic sym_bad;
    logic full;
    logic p_zero;
    logic tr_zero;
    logic tr_eq_q;
    logic len_match;
    logic idx_last;
    logic out_free;
  } sac_stat_t;

endpackage

// ===== rtl/sac_ram.sv =====
// Generic single-port RAM with registered read data.
// Used for the transition table, suffix links and state lengths.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write or read one entry per cycle; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ===== rtl/sac_dp.sv =====
// Datapath: automaton stores, working registers and result register.
// Depends on sac_pkg and sac_ram; driven by commands from sac_ctrl.
module sac_dp
  import sac_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sac_op_e         op_i,
  input  logic            in_kind_i,
  input  sym_t            in_sym_i,
  input  logic            in_restart_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output len_t            out_match_o,
  output len_t            out_best_o,
  output logic            out_full_o,
  output sac_stat_t       stat_o
);

  // Control registers
  state_t last_q, last_d, cnt_q, cnt_d, ms_q, ms_d;
  logic [TEXT_W-1:0] txt_q, txt_d;
  len_t cur_q, cur_d, best_q, best_d;
  sym_t idx_q, idx_d;
  logic out_valid_q, out_valid_d;

  // Payload registers
  state_t p_q, p_d, q_q, q_d, np_q, np_d, cl_q, cl_d;
  sym_t c_q, c_d;
  len_t lenq_q, lenq_d, lenp_q, lenp_d;
  logic kind_q, kind_d, restart_q, restart_d, bad_q, bad_d, full_q, full_d;
  len_t om_q, om_d, ob_q, ob_d;
  logic of_q, of_d;

  // RAM ports
  logic tr_en, tr_we, lk_en, lk_we, ln_en, ln_we;
  logic [TR_AW-1:0] tr_addr;
  state_t tr_wdata, tr_rdata, lk_addr, lk_wdata, lk_rdata, ln_addr;
  len_t ln_wdata, ln_rdata;
  logic full_cond;
  state_t p_start;

  sac_ram #(.WIDTH(STATE_W), .DEPTH(1 << TR_AW)) u_tr (
    .clk_i, .en_i(tr_en), .we_i(tr_we), .addr_i(tr_addr),
    .wdata_i(tr_wdata), .rdata_o(tr_rdata)
  );

  sac_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_link (
    .clk_i, .en_i(lk_en), .we_i(lk_we), .addr_i(lk_addr),
    .wdata_i(lk_wdata), .rdata_o(lk_rdata)
  );

  sac_ram #(.WIDTH(LEN_W), .DEPTH(MAX_STATES)) u_len (
    .clk_i, .en_i(ln_en), .we_i(ln_we), .addr_i(ln_addr),
    .wdata_i(ln_wdata), .rdata_o(ln_rdata)
  );

  assign full_cond = (int'(txt_q) >= MAX_TEXT) || (int'(cnt_q) + 2 > MAX_STATES - 1);
  assign p_start   = restart_q ? ROOT_STATE : ms_q;

  // Decode the command into store accesses and register updates
  always_comb begin
    tr_en = 1'b0; tr_we = 1'b0; tr_addr = {p_q, c_q}; tr_wdata = '0;
    lk_en = 1'b0; lk_we = 1'b0; lk_addr = p_q; lk_wdata = '0;
    ln_en = 1'b0; ln_we = 1'b0; ln_addr = p_q; ln_wdata = '0;
    last_d = last_q; cnt_d = cnt_q; ms_d = ms_q; txt_d = txt_q;
    cur_d = cur_q; best_d = best_q; idx_d = idx_q;
    p_d = p_q; q_d = q_q; np_d = np_q; cl_d = cl_q; c_d = c_q;
    lenq_d = lenq_q; lenp_d = lenp_q;
    kind_d = kind_q; restart_d = restart_q; bad_d = bad_q; full_d = full_q;
    om_d = om_q; ob_d = ob_q; of_d = of_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (op_i)
      OP_INIT_ROW: begin
        tr_en = 1'b1; tr_we = 1'b1; tr_addr = {ROOT_STATE, idx_q};
        idx_d = idx_q + 1'b1;
      end
      OP_INIT_LEN: begin
        ln_en = 1'b1; ln_we = 1'b1; ln_addr = ROOT_STATE;
        lk_en = 1'b1; lk_we = 1'b1; lk_addr = ROOT_STATE;
      end
      OP_ACCEPT: begin
        kind_d    = in_kind_i;
        c_d       = in_sym_i;
        restart_d = in_restart_i;
        bad_d     = int'(in_sym_i) >= ALPHABET;
        full_d    = !in_kind_i && (int'(in_sym_i) < ALPHABET) && full_cond;
        idx_d     = '0;
      end
      OP_T_START: begin
        np_d = cnt_q + 1'b1; cnt_d = cnt_q + 1'b1; p_d = last_q;
        ln_en = 1'b1; ln_addr = last_q;
      end
      OP_T_CLR: begin
        tr_en = 1'b1; tr_we = 1'b1; tr_addr = {np_q, idx_q};
        idx_d = idx_q + 1'b1;
      end
      OP_T_LENW: begin
        ln_en = 1'b1; ln_we = 1'b1; ln_addr = np_q; ln_wdata = ln_rdata + 1'b1;
      end
      OP_T_TOP: begin
        if (p_q != NULL_STATE) begin
          tr_en = 1'b1;
        end else begin
          lk_en = 1'b1; lk_we = 1'b1; lk_addr = np_q; lk_wdata = ROOT_STATE;
        end
      end
      OP_T_CHK: begin
        if (tr_rdata == NULL_STATE) begin
          tr_en = 1'b1; tr_we = 1'b1; tr_wdata = np_q;
          lk_en = 1'b1;
        end else begin
          q_d = tr_rdata;
          ln_en = 1'b1; ln_addr = tr_rdata;
        end
      end
      OP_FOLLOW: p_d = lk_rdata;
      OP_T_LQ: begin
        lenq_d = ln_rdata;
        ln_en = 1'b1;
      end
      OP_T_LP: begin
        lenp_d = ln_rdata;
        if (stat_o.len_match) begin
          lk_en = 1'b1; lk_we = 1'b1; lk_addr = np_q; lk_wdata = q_q;
        end else begin
          cl_d = cnt_q + 1'b1; cnt_d = cnt_q + 1'b1;
        end
      end
      OP_C_LEN: begin
        ln_en = 1'b1; ln_we = 1'b1; ln_addr = cl_q; ln_wdata = lenp_q + 1'b1;
        lk_en = 1'b1; lk_addr = q_q;
      end
      OP_C_LNK: begin
        lk_en = 1'b1; lk_we = 1'b1; lk_addr = cl_q; lk_wdata = lk_rdata;
      end
      OP_C_LNK2: begin
        lk_en = 1'b1; lk_we = 1'b1; lk_addr = q_q; lk_wdata = cl_q;
      end
      OP_C_LNK3: begin
        lk_en = 1'b1; lk_we = 1'b1; lk_addr = np_q; lk_wdata = cl_q;
        idx_d = '0;
      end
      OP_C_RD: begin
        tr_en = 1'b1; tr_addr = {q_q, idx_q};
      end
      OP_C_WR: begin
        tr_en = 1'b1; tr_we = 1'b1; tr_addr = {cl_q, idx_q}; tr_wdata = tr_rdata;
        idx_d = idx_q + 1'b1;
      end
      OP_R_TOP: tr_en = (p_q != NULL_STATE);
      OP_R_CHK: begin
        if (tr_rdata == q_q) begin
          tr_en = 1'b1; tr_we = 1'b1; tr_wdata = cl_q;
          lk_en = 1'b1;
        end
      end
      OP_T_DONE: begin
        last_d = np_q;
        txt_d  = txt_q + 1'b1;
      end
      OP_Q_START: begin
        if (restart_q) begin
          ms_d = ROOT_STATE; cur_d = '0; best_d = '0;
        end
        p_d = p_start;
        tr_en = 1'b1; tr_addr = {p_start, c_q};
      end
      OP_Q_BAD: begin
        ms_d = ROOT_STATE; cur_d = '0;
      end
      OP_Q_CHK0: begin
        if (tr_rdata != NULL_STATE) begin
          ms_d = tr_rdata; cur_d = cur_q + 1'b1;
        end else begin
          lk_en = 1'b1;
        end
      end
      OP_Q_TOP: begin
        if (p_q != NULL_STATE) begin
          tr_en = 1'b1;
        end else begin
          ms_d = ROOT_STATE; cur_d = '0;
        end
      end
      OP_Q_CHK: begin
        if (tr_rdata != NULL_STATE) begin
          q_d = tr_rdata;
          ln_en = 1'b1;
        end else begin
          lk_en = 1'b1;
        end
      end
      OP_Q_LEN: begin
        cur_d = ln_rdata + 1'b1; ms_d = q_q;
      end
      OP_Q_BEST: if (cur_q > best_q) best_d = cur_q;
      OP_PUT: begin
        om_d = cur_q; ob_d = best_q; of_d = full_q;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= ROOT_STATE; cnt_q <= ROOT_STATE; ms_q <= ROOT_STATE;
      txt_q <= '0; cur_q <= '0; best_q <= '0; idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q <= last_d; cnt_q <= cnt_d; ms_q <= ms_d;
      txt_q <= txt_d; cur_q <= cur_d; best_q <= best_d; idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working values
  always_ff @(posedge clk_i) begin
    p_q <= p_d; q_q <= q_d; np_q <= np_d; cl_q <= cl_d; c_q <= c_d;
    lenq_q <= lenq_d; lenp_q <= lenp_d;
    kind_q <= kind_d; restart_q <= restart_d; bad_q <= bad_d; full_q <= full_d;
    om_q <= om_d; ob_q <= ob_d; of_q <= of_d;
  end

  always_comb begin
    stat_o.kind      = kind_q;
    stat_o.sym_bad   = bad_q;
    stat_o.full      = full_q;
    stat_o.p_zero    = (p_q == NULL_STATE);
    stat_o.tr_zero   = (tr_rdata == NULL_STATE);
    stat_o.tr_eq_q   = (tr_rdata == q_q);
    stat_o.len_match = ({1'b0, lenq_q} == ({1'b0, ln_rdata} + 1'b1));
    stat_o.idx_last  = (int'(idx_q) == ALPHABET - 1);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_match_o = om_q;
  assign out_best_o  = ob_q;
  assign out_full_o  = of_q;

endmodule

// ===== rtl/sac_ctrl.sv =====
// Controller: sequences init, append, clone and match steps.
// Depends on sac_pkg; drives sac_dp through one command per cycle.
module sac_ctrl
  import sac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sac_stat_t stat_i,
  output sac_op_e   op_o
);

  typedef enum logic [4:0] {
    ST_INIT_ROW, ST_INIT_LEN, ST_IDLE, ST_DISPATCH,
    ST_T_START, ST_T_CLR, ST_T_LENW, ST_T_TOP, ST_T_CHK, ST_T_FOLLOW,
    ST_T_LQ, ST_T_LP, ST_C_LEN, ST_C_LNK, ST_C_LNK2, ST_C_LNK3,
    ST_C_RD, ST_C_WR, ST_R_TOP, ST_R_CHK, ST_R_FOLLOW, ST_T_DONE,
    ST_Q_START, ST_Q_BAD, ST_Q_CHK0, ST_Q_FOLLOW, ST_Q_TOP, ST_Q_CHK,
    ST_Q_LEN, ST_Q_BEST, ST_PUT
  } state_e;

  state_e state_q, state_d;

  // Decode command and next state
  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT_ROW: begin
        op_o = OP_INIT_ROW;
        if (stat_i.idx_last) state_d = ST_INIT_LEN;
      end
      ST_INIT_LEN: begin
        op_o = OP_INIT_LEN; state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = OP_ACCEPT; state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.kind) state_d = ST_Q_START;
        else if (stat_i.sym_bad || stat_i.full) state_d = ST_PUT;
        else state_d = ST_T_START;
      end
      ST_T_START: begin
        op_o = OP_T_START; state_d = ST_T_CLR;
      end
      ST_T_CLR: begin
        op_o = OP_T_CLR;
        if (stat_i.idx_last) state_d = ST_T_LENW;
      end
      ST_T_LENW: begin
        op_o = OP_T_LENW; state_d = ST_T_TOP;
      end
      ST_T_TOP: begin
        op_o = OP_T_TOP;
        state_d = stat_i.p_zero ? ST_T_DONE : ST_T_CHK;
      end
      ST_T_CHK: begin
        op_o = OP_T_CHK;
        state_d = stat_i.tr_zero ? ST_T_FOLLOW : ST_T_LQ;
      end
      ST_T_FOLLOW: begin
        op_o = OP_FOLLOW; state_d = ST_T_TOP;
      end
      ST_T_LQ: begin
        op_o = OP_T_LQ; state_d = ST_T_LP;
      end
      ST_T_LP: begin
        op_o = OP_T_LP;
        state_d = stat_i.len_match ? ST_T_DONE : ST_C_LEN;
      end
      ST_C_LEN: begin
        op_o = OP_C_LEN; state_d = ST_C_LNK;
      end
      ST_C_LNK: begin
        op_o = OP_C_LNK; state_d = ST_C_LNK2;
      end
      ST_C_LNK2: begin
        op_o = OP_C_LNK2; state_d = ST_C_LNK3;
      end
      ST_C_LNK3: begin
        op_o = OP_C_LNK3; state_d = ST_C_RD;
      end
      ST_C_RD: begin
        op_o = OP_C_RD; state_d = ST_C_WR;
      end
      ST_C_WR: begin
        op_o = OP_C_WR;
        state_d = stat_i.idx_last ? ST_R_TOP : ST_C_RD;
      end
      ST_R_TOP: begin
        op_o = OP_R_TOP;
        state_d = stat_i.p_zero ? ST_T_DONE : ST_R_CHK;
      end
      ST_R_CHK: begin
        op_o = OP_R_CHK;
        state_d = stat_i.tr_eq_q ? ST_R_FOLLOW : ST_T_DONE;
      end
      ST_R_FOLLOW: begin
        op_o = OP_FOLLOW; state_d = ST_R_TOP;
      end
      ST_T_DONE: begin
        op_o = OP_T_DONE; state_d = ST_PUT;
      end
      ST_Q_START: begin
        op_o = OP_Q_START;
        state_d = stat_i.sym_bad ? ST_Q_BAD : ST_Q_CHK0;
      end
      ST_Q_BAD: begin
        op_o = OP_Q_BAD; state_d = ST_Q_BEST;
      end
      ST_Q_CHK0: begin
        op_o = OP_Q_CHK0;
        state_d = stat_i.tr_zero ? ST_Q_FOLLOW : ST_Q_BEST;
      end
      ST_Q_FOLLOW: begin
        op_o = OP_FOLLOW; state_d = ST_Q_TOP;
      end
      ST_Q_TOP: begin
        op_o = OP_Q_TOP;
        state_d = stat_i.p_zero ? ST_Q_BEST : ST_Q_CHK;
      end
      ST_Q_CHK: begin
        op_o = OP_Q_CHK;
        state_d = stat_i.tr_zero ? ST_Q_FOLLOW : ST_Q_LEN;
      end
      ST_Q_LEN: begin
        op_o = OP_Q_LEN; state_d = ST_Q_BEST;
      end
      ST_Q_BEST: begin
        op_o = OP_Q_BEST; state_d = ST_PUT;
      end
      ST_PUT: begin
        if (stat_i.out_free) begin
          op_o = OP_PUT; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_ROW;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/suffix_automaton_common_substring.sv =====
// Top level: suffix automaton builder and longest-common-substring matcher.
// Depends on sac_pkg, sac_ctrl and sac_dp (which holds the sac_ram stores).
//
//   Channel  Dir  tdata                           tuser
//   s_axis   in   [4:0] symbol, [5] restart       [0] kind
//   m_axis   out  [9:0] match_length, [19:10] best [0] full_res
//
// One item at a time. A query follows suffix links until it finds a
// transition; an append clears the row of the new state (root-row-sized)
// and walks suffix links, and a clone copies the 26-entry row through the
// single-port transition RAM and then redirects transitions.
// After reset the root row is cleared and the root length and link written before s_axis_tready.
// A result waits in the output register; a stalled m_axis holds the block
// only when the next result is ready to be written.
module suffix_automaton_common_substring
  import sac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] symbol, [5] restart
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] match_length, [19:10] best_length
  output logic [0:0]  m_axis_tuser    // [0] full_res
);

  sac_op_e   op;
  sac_stat_t stat;
  len_t      out_match, out_best;
  logic      out_full;

  sac_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i(stat),
    .op_o(op)
  );

  sac_dp u_dp (
    .clk_i, .rst_ni,
    .op_i(op),
    .in_kind_i(s_axis_tuser[0]),
    .in_sym_i(s_axis_tdata[SYM_W-1:0]),
    .in_restart_i(s_axis_tdata[SYM_W]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_match_o(out_match),
    .out_best_o(out_best),
    .out_full_o(out_full),
    .stat_o(stat)
  );

  assign m_axis_tdata = {4'b0, out_best, out_match};
  assign m_axis_tuser = out_full;

endmodule

// ===== bench/tb_suffix_automaton_common_substring.sv =====
// Self-checking bench for suffix_automaton_common_substring: a stream driver
// and a monitor, checked against an in-bench automaton and matcher predictor.
// Depends on sac_pkg and the rtl top level only.
module tb_suffix_automaton_common_substring
  import sac_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int   LEN_CAP    = 1023;

  typedef struct packed {
    logic kind;
    sym_t sym;
    logic restart;
  } sym_beat_t;

  typedef struct packed {
    len_t match_len;
    len_t best_len;
    logic full;
  } match_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [4:0] symbol, [5] restart
  logic [0:0]  s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [9:0] match_length, [19:10] best_length
  logic [0:0]  m_axis_tuser;   // [0] full_res

  suffix_automaton_common_substring DUT (.*);

  // Predictor state: the automaton and the matcher
  int unsigned trans_tbl [MAX_STATES][ALPHABET];
  int unsigned link_tbl  [MAX_STATES];
  int unsigned len_tbl   [MAX_STATES];
  int unsigned last_st, st_count, txt_count, cur_st, cur_len, best_len;

  sym_beat_t  pending_beats[$];
  match_res_t expected_res[$];
  sym_t       text_hist[$];
  sym_beat_t  cur_beat;
  int         errors;
  int         beats_sent;
  bit         stim_done;
  int         rx_hold;
  bit         hold_done;

  function automatic int unsigned new_state();
    st_count++;
    for (int k = 0; k < ALPHABET; k++) trans_tbl[st_count][k] = 0;
    link_tbl[st_count] = 0;
    len_tbl[st_count]  = 0;
    return st_count;
  endfunction

  function automatic void extend_automaton(int unsigned c);
    int unsigned p, np, q, cl;
    p  = last_st;
    np = new_state();
    len_tbl[np] = len_tbl[p] + 1;
    while (p != 0 && trans_tbl[p][c] == 0) begin
      trans_tbl[p][c] = np;
      p = link_tbl[p];
    end
    if (p == 0) begin
      link_tbl[np] = ROOT_STATE;
    end else begin
      q = trans_tbl[p][c];
      if (len_tbl[q] == len_tbl[p] + 1) begin
        link_tbl[np] = q;
      end else begin
        // split q: the clone takes the shorter lengths
        cl = new_state();
        len_tbl[cl] = len_tbl[p] + 1;
        for (int k = 0; k < ALPHABET; k++) trans_tbl[cl][k] = trans_tbl[q][k];
        link_tbl[cl] = link_tbl[q];
        link_tbl[q]  = cl;
        link_tbl[np] = cl;
        while (p != 0 && trans_tbl[p][c] == q) begin
          trans_tbl[p][c] = cl;
          p = link_tbl[p];
        end
      end
    end
    last_st = np;
  endfunction

  function automatic match_res_t predict_match(sym_beat_t b);
    match_res_t r;
    int unsigned c, p;
    c = b.sym;
    r.full = 1'b0;
    if (b.kind == KIND_TEXT) begin
      if (c < ALPHABET) begin
        if (txt_count >= MAX_TEXT || st_count + 2 > MAX_STATES - 1) begin
          r.full = 1'b1;
        end else begin
          extend_automaton(c);
          txt_count++;
        end
      end
    end else begin
      if (b.restart) begin
        cur_st = ROOT_STATE; cur_len = 0; best_len = 0;
      end
      p = cur_st;
      if (c >= ALPHABET) begin
        p = ROOT_STATE; cur_len = 0;
      end else if (trans_tbl[p][c] != 0) begin
        p = trans_tbl[p][c]; cur_len++;
      end else begin
        // fall back along suffix links
        while (p != 0 && trans_tbl[p][c] == 0) p = link_tbl[p];
        if (p == 0) begin
          p = ROOT_STATE; cur_len = 0;
        end else begin
          cur_len = len_tbl[p] + 1;
          p = trans_tbl[p][c];
        end
      end
      cur_st = p;
      if (cur_len > best_len) best_len = cur_len;
    end
    r.match_len = len_t'(cur_len > LEN_CAP ? LEN_CAP : cur_len);
    r.best_len  = len_t'(best_len > LEN_CAP ? LEN_CAP : best_len);
    return r;
  endfunction

  function automatic void push_beat(logic kind, int sym, logic restart);
    sym_beat_t b;
    b.kind = kind; b.sym = sym_t'(sym); b.restart = restart;
    pending_beats.push_back(b);
    if (kind == KIND_TEXT && sym < ALPHABET) text_hist.push_back(sym_t'(sym));
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int tx_idle_pct();
    return beats_sent < 600 ? 9 : (beats_sent < 1200 ? 82 : 0);
  endfunction

  function automatic int rx_idle_pct();
    return beats_sent < 600 ? 82 : (beats_sent < 1200 ? 9 : 0);
  endfunction

  // Driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(predict_match(cur_beat));
        beats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_done && pending_beats.size() != 0 &&
            $urandom_range(99) >= tx_idle_pct()) begin
          cur_beat       = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_beat.restart, cur_beat.sym};
          s_axis_tuser  <= cur_beat.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    match_res_t exp_r, got_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = {m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tuser[0]};
        if (expected_res.size() == 0) begin
          $display("%t: unexpected result beat %h", $realtime, got_r);
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got_r.match_len !== exp_r.match_len) begin
            $display("%t: match_length expected %0d got %0d", $realtime,
                     exp_r.match_len, got_r.match_len);
            errors++;
          end
          if (got_r.best_len !== exp_r.best_len) begin
            $display("%t: best_length expected %0d got %0d", $realtime,
                     exp_r.best_len, got_r.best_len);
            errors++;
          end
          if (got_r.full !== exp_r.full) begin
            $display("%t: full_res expected %0d got %0d", $realtime,
                     exp_r.full, got_r.full);
            errors++;
          end
        end
      end
      // long hold-off once, to back the block up into its input
      if (!hold_done && beats_sent >= 300) begin
        hold_done = 1'b1;
        rx_hold   = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int asz, n, start, total;
    errors = 0; beats_sent = 0; stim_done = 0; hold_done = 0;
    for (int s = 0; s < MAX_STATES; s++) begin
      for (int k = 0; k < ALPHABET; k++) trans_tbl[s][k] = 0;
      link_tbl[s] = 0; len_tbl[s] = 0;
    end
    last_st = ROOT_STATE; st_count = 1; txt_count = 0;
    cur_st = ROOT_STATE; cur_len = 0; best_len = 0;

    // Directed: query on an empty automaton, out-of-alphabet symbols
    push_beat(KIND_QUERY, 0, 1'b1);
    push_beat(KIND_QUERY, 31, 1'b0);
    push_beat(KIND_TEXT, 31, 1'b1);
    push_beat(KIND_TEXT, 26, 1'b0);
    // text "abbab" (its second b forces a clone) then a letter at the top of the alphabet
    push_beat(KIND_TEXT, 0, 1'b0);
    push_beat(KIND_TEXT, 1, 1'b1);
    push_beat(KIND_TEXT, 1, 1'b0);
    push_beat(KIND_TEXT, 0, 1'b0);
    push_beat(KIND_TEXT, 1, 1'b0);
    push_beat(KIND_TEXT, 25, 1'b0);
    // queries: match, mismatch with suffix-link fallback, bad symbol, restart
    push_beat(KIND_QUERY, 1, 1'b1);
    push_beat(KIND_QUERY, 0, 1'b0);
    push_beat(KIND_QUERY, 1, 1'b0);
    push_beat(KIND_QUERY, 1, 1'b0);
    push_beat(KIND_QUERY, 0, 1'b0);
    push_beat(KIND_QUERY, 25, 1'b0);
    push_beat(KIND_QUERY, 2, 1'b0);
    push_beat(KIND_QUERY, 0, 1'b0);
    push_beat(KIND_QUERY, 30, 1'b0);
    push_beat(KIND_QUERY, 0, 1'b1);
    push_beat(KIND_QUERY, 1, 1'b0);

    // Random: text runs mostly over small alphabets, then queries mostly drawn from the text
    total = pending_beats.size();
    while (total < 1700) begin
      asz = ($urandom_range(9) == 0) ? ALPHABET : $urandom_range(4, 2);
      n = $urandom_range(60, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(49) == 0)
          push_beat(KIND_TEXT, $urandom_range(31, 26), 1'($urandom));
        else if ($urandom_range(3) == 0 && text_hist.size() > 3)
          push_beat(KIND_TEXT, text_hist[$urandom_range(text_hist.size() - 1)],
                    1'($urandom));
        else push_beat(KIND_TEXT, $urandom_range(asz - 1), 1'($urandom));
      end
      n = $urandom_range(30, 3);
      start = $urandom_range(text_hist.size() - 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0)
          push_beat(KIND_QUERY, $urandom_range(31), i == 0 || $urandom_range(19) == 0);
        else
          push_beat(KIND_QUERY, text_hist[(start + i) % text_hist.size()], i == 0);
      end
      total = total + 0;
      total = pending_beats.size();
    end
    stim_done = 1'b1;

    wait (pending_beats.size() == 0 && !s_axis_tvalid && expected_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_dp.sv
rtl/sac_ctrl.sv
rtl/suffix_automaton_common_substring.sv
bench/tb_suffix_automaton_common_substring.sv
